// File: hdl/ppsm_pkg.sv
// Shared constants and types of the pulse period speed meter.
package ppsm_pkg;

    // Default ring depth of pulse intervals.
    localparam int SAMPLES_DEF = 8;

    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int SCALE_W  = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 32'd1000000;

    // Configuration register indexes.
    localparam logic CFG_UPDATE_PERIOD = 1'b0;
    localparam logic CFG_SPEED_SCALE   = 1'b1;

    // Item kinds carried in tuser.
    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SUM_RD  = 5'b00010,
        ST_SUM_ACC = 5'b00100,
        ST_DIV     = 5'b01000,
        ST_OUT     = 5'b10000
    } state_t;

endpackage

// File: hdl/ppsm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ppsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/pulse_period_speed_meter.sv
// Top level of the pulse period speed meter: interval ring, averaging and speed division.
//
// A pulse beat (tuser = 0) stores the wrapping millisecond interval since the previous pulse
// into a ring of SAMPLES entries and is finished in the cycle it is accepted. A check beat
// (tuser = 1) whose elapsed time since the last update has not reached update_period_ms is
// also finished at once and gives no result. A check that reaches the period records now_ms
// as the new update time, then sums the ring through the ring RAM's registered read port,
// a read state and an accumulate state per entry, divides the sum by SAMPLES in a bit-serial
// restoring divider and, unless the average is zero, reuses that divider for
// speed_scale / average. The output state then loads the output register. Such a check
// therefore holds s_axis_tready low until its result is loaded; a zero average
// skips the second division and saturates speed with zero_interval set. The output
// state stretches while an earlier result still waits in the output register. A result
// waits in the output register while later pulse and short checks are still accepted.
module pulse_period_speed_meter #(
    parameter int SAMPLES = ppsm_pkg::SAMPLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] now_ms
    input  logic [0:0]  s_axis_tuser,   // [0] op

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] speed, [63:32] average_interval_ms
    output logic [0:0]  m_axis_tuser    // [0] zero_interval
);

    localparam int IDX_W  = $clog2(SAMPLES);
    localparam int T_W    = ppsm_pkg::TIME_W;
    localparam int SUM_W  = T_W + IDX_W;
    localparam int CNT_W  = $clog2(SUM_W + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

    // Configuration registers.
    logic [ppsm_pkg::PERIOD_W-1:0] period_reg;
    logic [ppsm_pkg::SCALE_W-1:0]  scale_reg;

    // Block state.
    ppsm_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [SAMPLES-1:0] valid_reg, valid_next;
    logic [T_W-1:0] last_pulse_reg, last_pulse_next;
    logic [T_W-1:0] last_update_reg, last_update_next;

    // Summation and division datapath.
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic rd_valid_reg, rd_valid_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] dvd_reg, dvd_next;
    logic [T_W-1:0] rem_reg, rem_next;
    logic [T_W-1:0] sor_reg, sor_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic phase_reg, phase_next;
    logic [T_W-1:0] avg_reg, avg_next;
    logic [T_W-1:0] speed_reg, speed_next;
    logic zero_reg, zero_next;

    // Output register.
    logic out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;
    logic out_zero_reg, out_zero_next;

    logic in_fire;
    logic [T_W-1:0] now_ms;
    logic [T_W-1:0] elapsed;
    logic period_reached;
    logic ram_wr_en;
    logic ram_rd_en;
    logic [T_W-1:0] ram_rd_data;
    logic [T_W:0] shifted;
    logic [T_W:0] diff;
    logic ge;

    assign s_axis_tready = (state_reg == ppsm_pkg::ST_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign now_ms = s_axis_tdata;
    assign elapsed = now_ms - last_update_reg;
    assign period_reached = (elapsed >= {{(T_W - ppsm_pkg::PERIOD_W){1'b0}}, period_reg});
    assign ram_wr_en = in_fire && (s_axis_tuser[0] == ppsm_pkg::OP_PULSE);
    assign ram_rd_en = (state_reg == ppsm_pkg::ST_SUM_RD);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_zero_reg;

    ppsm_ram #(
        .WIDTH (T_W),
        .DEPTH (SAMPLES)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (now_ms - last_pulse_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // One restoring division step: bring down the next dividend bit.
    assign shifted = {rem_reg, dvd_reg[SUM_W-1]};
    assign diff = shifted - {1'b0, sor_reg};
    assign ge = (shifted >= {1'b0, sor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= ppsm_pkg::PERIOD_RESET;
            scale_reg  <= ppsm_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppsm_pkg::CFG_UPDATE_PERIOD: period_reg <= cfg_data[ppsm_pkg::PERIOD_W-1:0];
                ppsm_pkg::CFG_SPEED_SCALE:   scale_reg  <= cfg_data[ppsm_pkg::SCALE_W-1:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        slot_next        = slot_reg;
        valid_next       = valid_reg;
        last_pulse_next  = last_pulse_reg;
        last_update_next = last_update_reg;
        idx_next         = idx_reg;
        rd_valid_next    = rd_valid_reg;
        sum_next         = sum_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        sor_next         = sor_reg;
        cnt_next         = cnt_reg;
        phase_next       = phase_reg;
        avg_next         = avg_reg;
        speed_next       = speed_reg;
        zero_next        = zero_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_zero_next    = out_zero_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ppsm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser[0] == ppsm_pkg::OP_PULSE)
                    begin
                        valid_next[slot_reg] = 1'b1;
                        last_pulse_next = now_ms;
                        slot_next = (slot_reg == LAST_IDX) ? '0 : slot_reg + 1'b1;
                    end
                    else if (period_reached)
                    begin
                        last_update_next = now_ms;
                        idx_next = '0;
                        sum_next = '0;
                        state_next = ppsm_pkg::ST_SUM_RD;
                    end
                end
            end
            ppsm_pkg::ST_SUM_RD:
            begin
                // Entries never written since reset count as zero.
                rd_valid_next = valid_reg[idx_reg];
                state_next = ppsm_pkg::ST_SUM_ACC;
            end
            ppsm_pkg::ST_SUM_ACC:
            begin
                if (rd_valid_reg)
                begin
                    sum_next = sum_reg + {{IDX_W{1'b0}}, ram_rd_data};
                end
                if (idx_reg == LAST_IDX)
                begin
                    dvd_next = sum_next;
                    sor_next = T_W'(SAMPLES);
                    rem_next = '0;
                    cnt_next = CNT_W'(SUM_W);
                    phase_next = 1'b0;
                    state_next = ppsm_pkg::ST_DIV;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ppsm_pkg::ST_SUM_RD;
                end
            end
            ppsm_pkg::ST_DIV:
            begin
                rem_next = ge ? diff[T_W-1:0] : shifted[T_W-1:0];
                dvd_next = {dvd_reg[SUM_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    if (!phase_reg)
                    begin
                        avg_next = dvd_next[T_W-1:0];
                        if (dvd_next[T_W-1:0] == '0)
                        begin
                            speed_next = '1;
                            zero_next = 1'b1;
                            state_next = ppsm_pkg::ST_OUT;
                        end
                        else
                        begin
                            // Second pass: speed_scale over the average.
                            dvd_next = {{IDX_W{1'b0}}, scale_reg};
                            sor_next = avg_next;
                            rem_next = '0;
                            cnt_next = CNT_W'(SUM_W);
                            phase_next = 1'b1;
                            zero_next = 1'b0;
                        end
                    end
                    else
                    begin
                        speed_next = dvd_next[T_W-1:0];
                        state_next = ppsm_pkg::ST_OUT;
                    end
                end
            end
            ppsm_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {avg_reg, speed_reg};
                    out_zero_next = zero_reg;
                    state_next = ppsm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ppsm_pkg::ST_IDLE;
            slot_reg        <= '0;
            valid_reg       <= '0;
            last_pulse_reg  <= '0;
            last_update_reg <= '0;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            phase_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            slot_reg        <= slot_next;
            valid_reg       <= valid_next;
            last_pulse_reg  <= last_pulse_next;
            last_update_reg <= last_update_next;
            idx_reg         <= idx_next;
            cnt_reg         <= cnt_next;
            phase_reg       <= phase_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= rd_valid_next;
        sum_reg      <= sum_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        sor_reg      <= sor_next;
        avg_reg      <= avg_next;
        speed_reg    <= speed_next;
        zero_reg     <= zero_next;
        out_data_reg <= out_data_next;
        out_zero_reg <= out_zero_next;
    end

endmodule

// File: tb/tb.sv
// Self-checking testbench of the pulse period speed meter: directed and random beats.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH    = ppsm_pkg::SAMPLES_DEF;
    // A due check keeps the block busy after its beat is accepted.
    localparam int SETTLE_CYCLES = 120;
    localparam int QUIET_LIMIT   = 4000;

    typedef struct packed {
        logic [31:0] speed;
        logic [31:0] average;
        logic        zero;
    } reading_t;

    class speed_meter_scoreboard;
        logic [31:0] ring [RING_DEPTH];
        int unsigned slot;
        logic [31:0] last_pulse_ms;
        logic [31:0] last_update_ms;
        logic [15:0] period_ms;
        logic [31:0] scale;
        reading_t    pending_readings[$];
        int unsigned mismatch_count;

        function new();
            foreach (ring[k])
                ring[k] = '0;
            slot           = 0;
            last_pulse_ms  = '0;
            last_update_ms = '0;
            period_ms      = ppsm_pkg::PERIOD_RESET;
            scale          = ppsm_pkg::SCALE_RESET;
            mismatch_count = 0;
        endfunction

        function void set_register(logic idx, logic [31:0] data);
            if (idx == ppsm_pkg::CFG_UPDATE_PERIOD)
                period_ms = data[15:0];
            else
                scale = data;
        endfunction

        function void note_beat(logic op, logic [31:0] now_ms);
            logic [34:0] total;
            logic [31:0] elapsed;
            reading_t    r;
            if (op == ppsm_pkg::OP_PULSE)
            begin
                ring[slot]    = now_ms - last_pulse_ms;
                last_pulse_ms = now_ms;
                slot          = (slot + 1) % RING_DEPTH;
                return;
            end
            elapsed = now_ms - last_update_ms;
            if (elapsed < {16'd0, period_ms})
                return;
            total = '0;
            foreach (ring[k])
                total += {3'd0, ring[k]};
            r.average = 32'(total / 35'(RING_DEPTH));
            if (r.average == '0)
            begin
                r.speed = '1;
                r.zero  = 1'b1;
            end
            else
            begin
                r.speed = scale / r.average;
                r.zero  = 1'b0;
            end
            last_update_ms = now_ms;
            pending_readings.push_back(r);
        endfunction

        function void check_reading(logic [31:0] speed, logic [31:0] average, logic zero);
            reading_t want;
            if (pending_readings.size() == 0)
            begin
                $display("%0t: result beat with none expected: speed %h average %h zero %b",
                         $time, speed, average, zero);
                mismatch_count++;
                return;
            end
            want = pending_readings.pop_front();
            if (speed !== want.speed)
            begin
                $display("%0t: speed expected %h, got %h", $time, want.speed, speed);
                mismatch_count++;
            end
            if (average !== want.average)
            begin
                $display("%0t: average_interval_ms expected %h, got %h",
                         $time, want.average, average);
                mismatch_count++;
            end
            if (zero !== want.zero)
            begin
                $display("%0t: zero_interval expected %b, got %b", $time, want.zero, zero);
                mismatch_count++;
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic        cfg_index     = ppsm_pkg::CFG_UPDATE_PERIOD;
    logic [31:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] now_ms
    logic [0:0]  s_axis_tuser  = '0;   // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // [31:0] speed, [63:32] average_interval_ms
    logic [0:0]  m_axis_tuser;         // [0] zero_interval

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned quiet_cycles       = 0;

    speed_meter_scoreboard readings = new();

    pulse_period_speed_meter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            readings.check_reading(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0]);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (rst_n)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Valid stays high from one beat to the next unless a gap is drawn.
    task automatic send_beat(input logic op, input logic [31:0] now_ms);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= now_ms;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        readings.note_beat(op, now_ms);
    endtask

    // Pulses and quiet checks give no result, so the block may still be busy when the
    // last reading arrives; the settle time covers a check still in progress.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (readings.pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        readings.set_register(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] period_word, input logic [31:0] scale_word);
        wait_drained();
        write_register(ppsm_pkg::CFG_UPDATE_PERIOD, period_word);
        write_register(ppsm_pkg::CFG_SPEED_SCALE, scale_word);
    endtask

    initial
    begin
        logic [31:0] stamp;
        logic [31:0] now_ms;
        logic        op;
        int unsigned span;
        int unsigned pick;
        int          mode;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The ring starts all zero: an early check stays quiet, the first due one saturates.
        send_beat(ppsm_pkg::OP_CHECK, 32'd500);
        send_beat(ppsm_pkg::OP_CHECK, 32'd1000);
        // Largest interval, then one across the time wrap.
        send_beat(ppsm_pkg::OP_PULSE, 32'hFFFF_FFFF);
        send_beat(ppsm_pkg::OP_PULSE, 32'h0000_0010);
        send_beat(ppsm_pkg::OP_PULSE, 32'h0000_0100);
        send_beat(ppsm_pkg::OP_CHECK, 32'd1999);
        send_beat(ppsm_pkg::OP_CHECK, 32'd2000);

        configure(32'd1, 32'hFFFF_FFFF);
        send_beat(ppsm_pkg::OP_CHECK, 32'd2000);
        send_beat(ppsm_pkg::OP_CHECK, 32'd2001);

        configure(32'd65535, 32'd1);
        send_beat(ppsm_pkg::OP_CHECK, 32'd67535);
        send_beat(ppsm_pkg::OP_CHECK, 32'd67536);

        // Each pulse one millisecond earlier than the last stores the largest interval,
        // so the whole ring ends up at its maximum.
        send_beat(ppsm_pkg::OP_PULSE, 32'd67536);
        for (int i = 1; i <= RING_DEPTH; i++)
            send_beat(ppsm_pkg::OP_PULSE, 32'd67536 - i);

        // A zero period lets every check update; a zero scale gives zero speed.
        configure(32'd0, 32'd0);
        send_beat(ppsm_pkg::OP_CHECK, 32'd67536);

        // Update time just below the wrap, then checks on the far side of it.
        configure({16'hA5C3, ppsm_pkg::PERIOD_RESET}, ppsm_pkg::SCALE_RESET);
        send_beat(ppsm_pkg::OP_CHECK, 32'hFFFF_FF00);
        send_beat(ppsm_pkg::OP_CHECK, 32'h0000_0100);
        send_beat(ppsm_pkg::OP_CHECK, 32'h0000_02E8);

        stamp = 32'h0000_1000;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: configure({16'd0, ppsm_pkg::PERIOD_RESET}, ppsm_pkg::SCALE_RESET);
                1: configure(32'd1, 32'hFFFF_FFFF);
                2: configure(32'd65535, 32'd1);
                3: configure($urandom_range(1, 65535), $urandom());
                4: configure(32'd0, $urandom());
                5: configure($urandom_range(1, 65535), 32'd0);
                6: configure($urandom_range(1, 64), $urandom_range(1, 32'hFFFF_FFFF));
                default: configure({16'($urandom()), 16'($urandom_range(1, 65535))},
                                   $urandom());
            endcase
            mode = phase % 4;
            sender_idle_pct    = (mode == 1) ? 54 : (mode == 3) ? 27 : 0;
            receiver_stall_pct = (mode == 2) ? 54 : (mode == 3) ? 27 : 0;
            if (phase == 3 || phase == 7)
                stamp = 32'hFFFF_FFFF - $urandom_range(0, 200000);

            for (int k = 0; k < 80; k++)
            begin
                if (k == 40)
                    wait_drained();
                span = readings.period_ms / 3 + 3;
                pick = $urandom_range(99);
                if (pick < 8)
                begin
                    // Out-of-order time stamps.
                    op     = 1'($urandom_range(1));
                    now_ms = $urandom();
                end
                else
                begin
                    op = ($urandom_range(99) < 55) ? ppsm_pkg::OP_PULSE : ppsm_pkg::OP_CHECK;
                    if (pick < 13)
                        stamp += $urandom();
                    else if (pick >= 18)
                        stamp += $urandom_range(0, span);
                    now_ms = stamp;
                end
                send_beat(op, now_ms);
            end
        end

        wait_drained();
        if (readings.mismatch_count == 0 && readings.pending_readings.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
